@@ design/drill_coordinate_field_parser_core_defines.svh @@
// Assertion macros used by the drill coordinate field parser top level.
`ifndef DRILL_COORDINATE_FIELD_PARSER_CORE_DEFINES_SVH
`define DRILL_COORDINATE_FIELD_PARSER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define DCFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcfp assertion failed");
// Next-cycle implication, checked out of reset
`define DCFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcfp assertion failed");
`else
`define DCFP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DCFP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/dcfp_pkg.sv @@
// Types, constants and helper functions of the drill coordinate field parser.
package dcfp_pkg;

    localparam int COORD_W = 41;
    localparam int CHARS_W = 6;
    localparam int PAD_W   = 4;
    localparam int P5_W    = 33;
    localparam int LO_W    = 21;
    localparam int HI_W    = COORD_W - LO_W;
    localparam int CNT_W   = 5;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Register indexes
    localparam logic [1:0] CFG_INT_DIGITS   = 2'd0;
    localparam logic [1:0] CFG_FRAC_DIGITS  = 2'd1;
    localparam logic [1:0] CFG_LEADING_ZERO = 2'd2;

    typedef struct packed {
        logic [2:0] int_digits;
        logic [2:0] fraction_digits;
        logic       leading_zero_format;
    } cfg_t;

    // Finished field on its way through the scaling stages
    typedef struct packed {
        logic [COORD_W-1:0] coord;
        logic [PAD_W-1:0]   pad;
        logic               neg;
        logic               ovf;
        logic [CHARS_W-1:0] chars;
        logic               empty;
    } field_t;

    // Ten to the power n, used at elaboration only
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            r = r * 64'd10;
        end
        return r;
    endfunction

    // Saturated magnitude, 10^n - 1, cut to the coordinate width
    function automatic logic [COORD_W-1:0] sat_value(input int n);
        logic [63:0] full;
        full = pow10(n) - 64'd1;
        return full[COORD_W-1:0];
    endfunction

    // Five to the power of the pad count; padding never exceeds 14 digits
    function automatic logic [P5_W-1:0] pow5(input logic [PAD_W-1:0] n);
        logic [P5_W-1:0] r;
        case (n)
            4'd0:    r = 33'd1;
            4'd1:    r = 33'd5;
            4'd2:    r = 33'd25;
            4'd3:    r = 33'd125;
            4'd4:    r = 33'd625;
            4'd5:    r = 33'd3125;
            4'd6:    r = 33'd15625;
            4'd7:    r = 33'd78125;
            4'd8:    r = 33'd390625;
            4'd9:    r = 33'd1953125;
            4'd10:   r = 33'd9765625;
            4'd11:   r = 33'd48828125;
            4'd12:   r = 33'd244140625;
            4'd13:   r = 33'd1220703125;
            4'd14:   r = 33'd6103515625;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

@@ design/drill_coordinate_field_parser_core.sv @@
// Top level of the drill coordinate field parser: config registers and stage wiring.
//
// Usage:
//   s_* carries one ASCII character per item (0 ends a line). Signs, digits
//   and points build up a field; any other character ends it and yields one
//   result on m_*, then is dropped. A sign counts only as the first character.
//   m_tdata holds the scaled signed coordinate and the character count;
//   m_tuser holds the empty-field and overflow flags.
//   cfg_* writes int_digits (0), fraction_digits (1) and leading_zero_format
//   (2); cfg_ready is always high and a write acts on the next cycle.
// Throughput: one character per cycle, except that a terminator waits while the
//   stages ahead are full; set by the field state update (multiply by ten as
//   shift-and-add plus the digit).
// Path: a result shows on m_tvalid once its terminating character has passed the
//   character register, field register, partial product register and output register.
// Reset: clears the field state and loads the format 2.4 with leading zeros.
// Stall: a waiting result holds m_*; characters that add to the next field
//   are still taken, and the next terminator waits until the stages ahead
//   have room.
`include "drill_coordinate_field_parser_core_defines.svh"

module drill_coordinate_field_parser_core #(
    parameter int MAX_DIGITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [40:0] coord_value, [46:41] chars_used, [47] zero
    output logic [1:0]  m_tuser,   // [0] empty_error, [1] overflow
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data
);
    import dcfp_pkg::*;

    localparam logic [COORD_W-1:0] SAT_POS = sat_value(MAX_DIGITS);
    localparam logic [COORD_W-1:0] SAT_NEG = ~SAT_POS + 1'b1;

    cfg_t               cfg_reg;
    field_t             fld;
    logic               fld_valid, fld_ready;
    logic [COORD_W-1:0] coord_value;
    logic [CHARS_W-1:0] chars_used;
    logic               empty_error, overflow;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.int_digits          <= 3'd2;
            cfg_reg.fraction_digits     <= 3'd4;
            cfg_reg.leading_zero_format <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INT_DIGITS:   cfg_reg.int_digits          <= cfg_data;
                CFG_FRAC_DIGITS:  cfg_reg.fraction_digits     <= cfg_data;
                CFG_LEADING_ZERO: cfg_reg.leading_zero_format <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    dcfp_parse #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_char   (s_tdata),
        .res_valid (fld_valid),
        .res_ready (fld_ready),
        .res       (fld)
    );

    dcfp_scale #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (fld_valid),
        .in_ready    (fld_ready),
        .fld         (fld),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .coord_value (coord_value),
        .chars_used  (chars_used),
        .empty_error (empty_error),
        .overflow    (overflow)
    );

    // Output packing
    assign m_tdata = {1'b0, chars_used, coord_value};
    assign m_tuser = {overflow, empty_error};

    // Checks
    `DCFP_ASSERT_IMP(a_ovf_saturates, clk, rst_n, m_tvalid && overflow, coord_value == SAT_POS || coord_value == SAT_NEG)
    `DCFP_ASSERT_IMP(a_empty_is_zero, clk, rst_n, m_tvalid && empty_error && !overflow, coord_value == '0 && chars_used == CHARS_W'(1))
    `DCFP_ASSERT_IMP(a_chars_nonzero, clk, rst_n, m_tvalid, chars_used != '0)
    `DCFP_ASSERT_NXT(a_cfg_frac_write, clk, rst_n, cfg_valid && cfg_ready && cfg_index == CFG_FRAC_DIGITS, cfg_reg.fraction_digits == $past(cfg_data))

endmodule

@@ design/dcfp_parse.sv @@
// Character register, field state and finished-field register of the parser.
module dcfp_parse #(
    parameter int MAX_DIGITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dcfp_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_char,
    output logic                 res_valid,
    input  logic                 res_ready,
    output dcfp_pkg::field_t     res
);
    import dcfp_pkg::*;

    localparam int ACC_BITS = $clog2(pow10(MAX_DIGITS));
    localparam int ACC_W    = (ACC_BITS < COORD_W) ? ACC_BITS : COORD_W;

    logic [7:0]         char_reg;
    logic               char_valid_reg;
    logic [ACC_W-1:0]   mag_reg, mag_next;
    logic [CNT_W-1:0]   digit_count_reg, digit_count_next;
    logic [CNT_W-1:0]   point_pos_reg, point_pos_next;
    logic               neg_reg, neg_next;
    logic               saw_point_reg, saw_point_next;
    logic [CHARS_W-1:0] field_len_reg, field_len_next;
    logic               sat_reg, sat_next;
    logic               res_valid_reg;
    field_t             res_reg, res_next;

    logic               at_start;
    logic               is_sign, is_digit, is_point, is_term;
    logic               slot_free, consume;
    logic [CHARS_W-1:0] len_inc;
    logic [ACC_W-1:0]   mag_x10;
    logic [3:0]         want;
    logic [PAD_W-1:0]   pad;
    logic [CHARS_W-1:0] digits_total;
    logic [COORD_W-1:0] mag_ext;

    // Character classes
    assign at_start = (field_len_reg == '0);
    assign is_sign  = at_start && ((char_reg == CH_PLUS) || (char_reg == CH_MINUS));
    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign is_point = (char_reg == CH_POINT);
    assign is_term  = !(is_sign || is_digit || is_point);

    // Only a terminator needs room downstream
    assign slot_free = !res_valid_reg || res_ready;
    assign consume   = char_valid_reg && (!is_term || slot_free);
    assign in_ready  = !char_valid_reg || consume;

    assign len_inc = (field_len_reg == {CHARS_W{1'b1}}) ? field_len_reg
                                                        : field_len_reg + 1'b1;
    assign mag_x10 = (mag_reg << 3) + (mag_reg << 1) + ACC_W'(char_reg[3:0]);

    // Trailing-zero count and overflow for the finished field
    always_comb
    begin
        want = {1'b0, cfg.int_digits} + {1'b0, cfg.fraction_digits};
        pad  = '0;
        if (saw_point_reg)
        begin
            if ({2'b00, cfg.fraction_digits} > point_pos_reg)
                pad = PAD_W'({2'b00, cfg.fraction_digits} - point_pos_reg);
        end
        else if (cfg.leading_zero_format)
        begin
            if ({1'b0, want} > digit_count_reg)
                pad = PAD_W'({1'b0, want} - digit_count_reg);
        end
        digits_total = {1'b0, digit_count_reg} + {2'b00, pad};
    end

    // Sign applied before scaling; products are taken modulo the output width
    always_comb
    begin
        mag_ext          = COORD_W'(mag_reg);
        res_next.coord   = neg_reg ? (~mag_ext + 1'b1) : mag_ext;
        res_next.pad     = pad;
        res_next.neg     = neg_reg;
        res_next.ovf     = sat_reg || (digits_total > CHARS_W'(MAX_DIGITS));
        res_next.chars   = at_start ? CHARS_W'(1) : field_len_reg;
        res_next.empty   = at_start;
    end

    // Field state update for the character being consumed
    always_comb
    begin
        mag_next         = mag_reg;
        digit_count_next = digit_count_reg;
        point_pos_next   = point_pos_reg;
        neg_next         = neg_reg;
        saw_point_next   = saw_point_reg;
        field_len_next   = field_len_reg;
        sat_next         = sat_reg;
        if (consume)
        begin
            if (is_sign)
            begin
                neg_next       = (char_reg == CH_MINUS);
                field_len_next = len_inc;
            end
            else if (is_digit)
            begin
                if (digit_count_reg < CNT_W'(MAX_DIGITS))
                begin
                    mag_next         = mag_x10;
                    digit_count_next = digit_count_reg + 1'b1;
                end
                else
                begin
                    sat_next = 1'b1;
                end
                if (point_pos_reg != {CNT_W{1'b1}})
                    point_pos_next = point_pos_reg + 1'b1;
                field_len_next = len_inc;
            end
            else if (is_point)
            begin
                saw_point_next = 1'b1;
                point_pos_next = '0;
                field_len_next = len_inc;
            end
            else
            begin
                mag_next         = '0;
                digit_count_next = '0;
                point_pos_next   = '0;
                neg_next         = 1'b0;
                saw_point_next   = 1'b0;
                field_len_next   = '0;
                sat_next         = 1'b0;
            end
        end
    end

    // Control and field state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
            mag_reg         <= '0;
            digit_count_reg <= '0;
            point_pos_reg   <= '0;
            neg_reg         <= 1'b0;
            saw_point_reg   <= 1'b0;
            field_len_reg   <= '0;
            sat_reg         <= 1'b0;
        end
        else
        begin
            if (in_ready)
                char_valid_reg <= in_valid;
            if (slot_free)
                res_valid_reg <= consume && is_term;
            mag_reg         <= mag_next;
            digit_count_reg <= digit_count_next;
            point_pos_reg   <= point_pos_next;
            neg_reg         <= neg_next;
            saw_point_reg   <= saw_point_next;
            field_len_reg   <= field_len_next;
            sat_reg         <= sat_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            char_reg <= in_char;
        if (consume && is_term)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ design/dcfp_scale.sv @@
// Trailing-zero scaling: split multiply by 5^pad, then shift by pad and saturate.
module dcfp_scale #(
    parameter int MAX_DIGITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  dcfp_pkg::field_t             fld,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dcfp_pkg::COORD_W-1:0] coord_value,
    output logic [dcfp_pkg::CHARS_W-1:0] chars_used,
    output logic                         empty_error,
    output logic                         overflow
);
    import dcfp_pkg::*;

    localparam logic [COORD_W-1:0] SAT_POS = sat_value(MAX_DIGITS);
    localparam logic [COORD_W-1:0] SAT_NEG = ~SAT_POS + 1'b1;

    logic [P5_W-1:0]        p5;
    logic [LO_W+P5_W-1:0]   lo_prod;
    logic [HI_W+P5_W-1:0]   hi_prod;
    logic [COORD_W-1:0]     lo_pp_reg;
    logic [HI_W-1:0]        hi_pp_reg;
    field_t                 p_reg;
    logic                   p_valid_reg;
    logic                   p_ready;
    logic [COORD_W-1:0]     shifted, final_val;
    logic [COORD_W-1:0]     coord_reg;
    logic [CHARS_W-1:0]     chars_reg;
    logic                   empty_reg, ovf_reg, out_valid_reg;

    assign p_ready  = !out_valid_reg || out_ready;
    assign in_ready = !p_valid_reg || p_ready;

    // Partial products of the signed field value by 5^pad
    assign p5      = pow5(fld.pad);
    assign lo_prod = fld.coord[LO_W-1:0] * p5;
    assign hi_prod = fld.coord[COORD_W-1:LO_W] * p5;

    // Recombine, multiply by 2^pad, pick the saturated value on overflow
    assign shifted   = lo_pp_reg + {hi_pp_reg, {LO_W{1'b0}}};
    assign final_val = p_reg.ovf ? (p_reg.neg ? SAT_NEG : SAT_POS) : (shifted << p_reg.pad);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                p_valid_reg <= in_valid;
            if (p_ready)
                out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            lo_pp_reg <= lo_prod[COORD_W-1:0];
            hi_pp_reg <= hi_prod[HI_W-1:0];
            p_reg     <= fld;
        end
        if (p_valid_reg && p_ready)
        begin
            coord_reg <= final_val;
            chars_reg <= p_reg.chars;
            empty_reg <= p_reg.empty;
            ovf_reg   <= p_reg.ovf;
        end
    end

    assign out_valid   = out_valid_reg;
    assign coord_value = coord_reg;
    assign chars_used  = chars_reg;
    assign empty_error = empty_reg;
    assign overflow    = ovf_reg;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the drill coordinate field parser core.
`timescale 1ns / 100ps

module tb;
    import dcfp_pkg::*;

    localparam int MAX_DIGITS   = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 12;
    localparam int HOLD_PHASE   = 3;

    // Index past the register list, must be ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Characters that end a field
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_TOP   = 8'hFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord;
        logic [CHARS_W-1:0]        chars;
        logic                      empty;
        logic                      ovf;
    } coord_res_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        coord_res_t res;
    } char_item_t;

    typedef struct {
        string      text;
        logic [7:0] term;
        logic       typed;
        coord_res_t res;
    } field_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [2:0]  cfg_data = 3'd0;

    // Field state and format as the parser should hold them
    logic [39:0] fld_mag = '0;
    logic [4:0]  fld_digits = '0;
    logic [4:0]  fld_frac_pos = '0;
    logic        fld_neg = 1'b0;
    logic        fld_point = 1'b0;
    logic [5:0]  fld_len = '0;
    logic        fld_start = 1'b1;
    logic        fld_sat = 1'b0;
    logic [2:0]  fmt_int = 3'd2;
    logic [2:0]  fmt_frac = 3'd4;
    logic        fmt_lz = 1'b1;

    char_item_t  char_q[$];
    coord_res_t  coord_q[$];
    char_item_t  cur_item = '0;
    int          fails = 0;
    int          quiet = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_req = 1'b0;

    // Directed fields, format 2.4 with leading zeros (reset values)
    field_row_t field_tab[6] = '{
        '{"",              CH_NUL,   1'b1, '{41'sd0, 6'd1, 1'b1, 1'b0}},
        '{"-",             CH_NUL,   1'b1, '{41'sd0, 6'd1, 1'b0, 1'b0}},
        '{"5",             CH_MINUS, 1'b1, '{41'sd500000, 6'd1, 1'b0, 1'b0}},
        '{"-1.5",          CH_TOP,   1'b1, '{-41'sd15000, 6'd4, 1'b0, 1'b0}},
        '{"9999999999999", CH_NUL,   1'b1, '{41'sd999999999999, 6'd13, 1'b0, 1'b1}},
        '{"+.7",           CH_COMMA, 1'b0, '0}
    };

    int set_int[8]  = '{2, 0, 0, 7, 7, 7, 0, 3};
    int set_frac[8] = '{4, 0, 0, 7, 7, 0, 7, 3};
    int set_lz[8]   = '{1, 0, 1, 1, 0, 1, 1, 0};

    drill_coordinate_field_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] ten_pow(input int n);
        logic [63:0] acc;
        acc = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            acc = acc * 64'd10;
        end
        return acc;
    endfunction

    function void count_char();
        if (fld_len != 6'd63)
            fld_len = fld_len + 6'd1;
        fld_start = 1'b0;
    endfunction

    // Advance the field by one character; returns 1 when it ends a field
    function bit parse_char(input logic [7:0] c, output coord_res_t r);
        int          pad;
        int          want;
        logic [63:0] mag;
        logic        ovf;
        pad = 0;
        r = '0;
        if (fld_start && (c == CH_PLUS || c == CH_MINUS))
        begin
            fld_neg = (c == CH_MINUS);
            count_char();
            return 1'b0;
        end
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (fld_digits < MAX_DIGITS)
            begin
                fld_mag = fld_mag * 40'd10 + 40'(c - CH_ZERO);
                fld_digits = fld_digits + 5'd1;
            end
            else
                fld_sat = 1'b1;
            if (fld_frac_pos != 5'd31)
                fld_frac_pos = fld_frac_pos + 5'd1;
            count_char();
            return 1'b0;
        end
        if (c == CH_POINT)
        begin
            fld_point = 1'b1;
            fld_frac_pos = '0;
            count_char();
            return 1'b0;
        end

        // Field ends: pad with trailing zeros, saturate on too many digits
        if (fld_point)
        begin
            if (int'(fmt_frac) > int'(fld_frac_pos))
                pad = int'(fmt_frac) - int'(fld_frac_pos);
        end
        else if (fmt_lz)
        begin
            want = int'(fmt_int) + int'(fmt_frac);
            if (want > int'(fld_digits))
                pad = want - int'(fld_digits);
        end
        ovf = fld_sat || (int'(fld_digits) + pad > MAX_DIGITS);
        if (ovf)
            mag = ten_pow(MAX_DIGITS) - 64'd1;
        else
            mag = {24'd0, fld_mag} * ten_pow(pad);
        if (fld_neg)
            mag = -mag;
        r.coord = mag[COORD_W-1:0];
        r.chars = (fld_len == 0) ? 6'd1 : fld_len;
        r.empty = (fld_len == 0);
        r.ovf   = ovf;

        fld_mag      = '0;
        fld_digits   = '0;
        fld_frac_pos = '0;
        fld_neg      = 1'b0;
        fld_point    = 1'b0;
        fld_len      = '0;
        fld_start    = 1'b1;
        fld_sat      = 1'b0;
        return 1'b1;
    endfunction

    function void add_char(input logic [7:0] c);
        char_q.push_back('{ch: c, typed: 1'b0, res: '0});
    endfunction

    function automatic logic [7:0] pick_term();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0:       c = CH_NUL;
            1:       c = CH_COMMA;
            2:       c = CH_X;
            3:       c = CH_Y;
            4:       c = CH_TOP;
            default:
            begin
                // any byte that is no digit or point; a sign ends a non-empty field
                c = 8'($urandom_range(0, 255));
                while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_POINT)
                    c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    // Queue one random field: mostly well-formed, some long, some noise
    function automatic void add_random_field();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            n = $urandom_range(1, 4);
            repeat (n) add_char(8'($urandom_range(0, 255)));
            return;
        end
        if (kind < 11)
        begin
            // long field: the fraction position saturates and the character count may saturate
            if ($urandom_range(0, 1) == 1)
                add_char(CH_POINT);
            n = $urandom_range(35, 80);
            repeat (n) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
            add_char(pick_term());
            return;
        end
        case ($urandom_range(0, 2))
            0:       add_char(CH_PLUS);
            1:       add_char(CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 7);
        repeat (n) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 9) < 4)
        begin
            add_char(CH_POINT);
            n = $urandom_range(0, 8);
            repeat (n) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
            // a second point restarts the fraction count
            if ($urandom_range(0, 9) == 0)
            begin
                add_char(CH_POINT);
                n = $urandom_range(0, 3);
                repeat (n) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        add_char(pick_term());
    endfunction

    // Offer every queued character, with random gaps
    task automatic send_chars();
        char_item_t it;
        while (char_q.size() != 0)
        begin
            it = char_q.pop_front();
            if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= it.ch;
            cur_item <= it;
            do
                @(posedge clk);
            while (!(s_tvalid && s_tready));
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
    endtask

    // Wait for every expected result, then let the pipeline drain
    task automatic settle();
        @(posedge clk);
        while (coord_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: random stalls, one long hold on request
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Prediction, checking and stall watchdog
    always @(posedge clk)
    begin : monitor
        coord_res_t pred;
        coord_res_t got;
        coord_res_t want;
        bit         made;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INT_DIGITS:   fmt_int  = cfg_data;
                    CFG_FRAC_DIGITS:  fmt_frac = cfg_data;
                    CFG_LEADING_ZERO: fmt_lz   = cfg_data[0];
                    default:          ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                made = parse_char(s_tdata, pred);
                if (cur_item.typed)
                    coord_q.push_back(cur_item.res);
                else if (made)
                    coord_q.push_back(pred);
            end

            if (m_tvalid && m_tready)
            begin
                got.coord = m_tdata[COORD_W-1:0];
                got.chars = m_tdata[COORD_W+CHARS_W-1:COORD_W];
                got.empty = m_tuser[0];
                got.ovf   = m_tuser[1];
                if (coord_q.size() == 0)
                begin
                    $error("result with none expected: coord_value %0d", got.coord);
                    fails++;
                end
                else
                begin
                    want = coord_q.pop_front();
                    if (got.coord !== want.coord)
                    begin
                        $error("coord_value: expected %0d, got %0d", want.coord, got.coord);
                        fails++;
                    end
                    if (got.chars !== want.chars)
                    begin
                        $error("chars_used: expected %0d, got %0d", want.chars, got.chars);
                        fails++;
                    end
                    if (got.empty !== want.empty)
                    begin
                        $error("empty_error: expected %0b, got %0b", want.empty, got.empty);
                        fails++;
                    end
                    if (got.ovf !== want.ovf)
                    begin
                        $error("overflow: expected %0b, got %0b", want.ovf, got.ovf);
                        fails++;
                    end
                end
            end

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial
    begin : stimulus
        int f_int;
        int f_frac;
        int f_lz;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed fields at the reset format
        foreach (field_tab[i])
        begin
            for (int k = 0; k < field_tab[i].text.len(); k++)
                add_char(field_tab[i].text[k]);
            char_q.push_back('{ch: field_tab[i].term, typed: field_tab[i].typed,
                               res: field_tab[i].res});
        end
        send_chars();
        settle();

        // random phases, each at its own format
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase < 8)
            begin
                f_int  = set_int[phase];
                f_frac = set_frac[phase];
                f_lz   = set_lz[phase];
            end
            else
            begin
                f_int  = $urandom_range(0, 7);
                f_frac = $urandom_range(0, 7);
                f_lz   = $urandom_range(0, 1);
            end
            if (phase == 0 || $urandom_range(0, 2) == 0)
                write_reg(CFG_UNUSED, 3'($urandom_range(0, 7)));
            write_reg(CFG_INT_DIGITS, 3'(f_int));
            write_reg(CFG_FRAC_DIGITS, 3'(f_frac));
            write_reg(CFG_LEADING_ZERO, {2'($urandom_range(0, 3)), 1'(f_lz)});
            cfg_valid <= 1'b0;

            // the closing phase and every third phase run flat out on both sides
            if (phase == NUM_PHASES - 1 || phase % 3 == 2)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = $urandom_range(10, 40);
                rx_idle_pct = $urandom_range(10, 40);
            end
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;

            while (char_q.size() < PHASE_ITEMS)
                add_random_field();
            send_chars();
            settle();
        end

        if (fails == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
